// File: rtl/dbpsf_pkg.sv
// ----------------------------------------------------------------------------
// dbpsf_pkg
// Shared widths, defaults and register indexes for the page size finder.
// ----------------------------------------------------------------------------
package dbpsf_pkg;

    // default parameter values
    localparam int ADDR_BITS_DEF       = 64;
    localparam int SMALL_PAGE_BITS_DEF = 12;

    // stream widths: input is address + length, output is one size
    localparam int S_TDATA_W = 96;
    localparam int M_TDATA_W = 64;
    localparam int SEG_LEN_W = 32;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_SUPPORTED_SIZES = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_IOVA      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_LENGTH   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_OFFSET    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ODP_MODE        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ODP_PAGE_SHIFT  = 3'd5;

    localparam int FIRST_OFFSET_W = 12;
    localparam int PAGE_SHIFT_W   = 6;

endpackage

// File: rtl/dma_best_page_size_finder_unit.sv
// ----------------------------------------------------------------------------
// dma_best_page_size_finder_unit
// Finds the largest supported page size that maps a DMA region whose
// segments arrive one per transfer; reports it on the last segment.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                    payload
//  s_axis    in         s_axis_tvalid/s_axis_tready  tdata: seg_address, seg_length
//                                                    tlast: last_segment
//  m_axis    out        m_axis_tvalid/m_axis_tready  tdata: best_page_size
//  cfg       in         i_cfg_valid/o_cfg_ready      i_cfg_index, i_cfg_data
//
//  One segment per cycle sustained while the output is not stalled; a result
//  passes the input register, the segment update and the size selection
//  stages before it is valid.
//  The segment update stage carries the region state from one segment to the
//  next. Synchronous active-low reset returns the region state to idle, clears
//  the valid flags and loads the configuration registers with their defaults.
//  A stalled output freezes the pipeline; one segment is held in the skid
//  register, so s_axis_tready only depends on registered state.
// ----------------------------------------------------------------------------
module dma_best_page_size_finder_unit
    import dbpsf_pkg::*;
#(
    parameter int ADDR_BITS       = ADDR_BITS_DEF,
    parameter int SMALL_PAGE_BITS = SMALL_PAGE_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input segments
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [S_TDATA_W-1:0]  s_axis_tdata,   // [63:0] seg_address, [95:64] seg_length
    input  logic                  s_axis_tlast,   // last_segment
    // results
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [M_TDATA_W-1:0]  m_axis_tdata,   // [63:0] best_page_size
    // configuration writes
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int AW = ADDR_BITS;
    localparam logic [AW-1:0] OFF_MASK = AW'((64'd1 << SMALL_PAGE_BITS) - 64'd1);

    // fill every bit below the highest set bit
    function automatic logic [63:0] f_smear(input logic [63:0] x);
        logic [63:0] y;
        y = x;
        y = y | (y >> 1);
        y = y | (y >> 2);
        y = y | (y >> 4);
        y = y | (y >> 8);
        y = y | (y >> 16);
        y = y | (y >> 32);
        return y;
    endfunction

    // configuration registers
    logic [63:0]               r_supported_sizes;
    logic [63:0]               r_start_iova;
    logic [63:0]               r_region_length;
    logic [FIRST_OFFSET_W-1:0] r_first_offset;
    logic                      r_odp_mode;
    logic [PAGE_SHIFT_W-1:0]   r_odp_page_shift;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_supported_sizes <= '0;
            r_start_iova      <= '0;
            r_region_length   <= 64'd1;
            r_first_offset    <= '0;
            r_odp_mode        <= 1'b0;
            r_odp_page_shift  <= PAGE_SHIFT_W'(12);
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_SUPPORTED_SIZES: r_supported_sizes <= i_cfg_data;
                CFG_START_IOVA:      r_start_iova      <= i_cfg_data;
                CFG_REGION_LENGTH:   r_region_length   <= i_cfg_data;
                CFG_FIRST_OFFSET:    r_first_offset    <= i_cfg_data[FIRST_OFFSET_W-1:0];
                CFG_ODP_MODE:        r_odp_mode        <= i_cfg_data[0];
                CFG_ODP_PAGE_SHIFT:  r_odp_page_shift  <= i_cfg_data[PAGE_SHIFT_W-1:0];
                default: ;
            endcase
        end
    end

    // pipeline advance: held only while a result waits on a stalled output
    logic r_c_valid;
    logic adv;
    assign adv = !(r_c_valid && !m_axis_tready);

    // skid register and input stage
    logic                 r_k_valid;
    logic [63:0]          r_k_addr;
    logic [SEG_LEN_W-1:0] r_k_len;
    logic                 r_k_last;

    logic                 r_a_valid;
    logic [63:0]          r_a_addr;
    logic [SEG_LEN_W-1:0] r_a_len;
    logic                 r_a_last;

    logic s_xfer;
    assign s_axis_tready = !r_k_valid;
    assign s_xfer        = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k_valid <= 1'b0;
            r_a_valid <= 1'b0;
        end else if (adv) begin
            r_k_valid <= 1'b0;
            r_a_valid <= r_k_valid || s_xfer;
        end else if (s_xfer) begin
            r_k_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!adv && s_xfer) begin
            r_k_addr <= s_axis_tdata[63:0];
            r_k_len  <= s_axis_tdata[95:64];
            r_k_last <= s_axis_tlast;
        end
        if (adv) begin
            if (r_k_valid) begin
                r_a_addr <= r_k_addr;
                r_a_len  <= r_k_len;
                r_a_last <= r_k_last;
            end else begin
                r_a_addr <= s_axis_tdata[63:0];
                r_a_len  <= s_axis_tdata[95:64];
                r_a_last <= s_axis_tlast;
            end
        end
    end

    // region state
    logic [AW-1:0] r_diff_mask,  n_diff_mask;
    logic [AW-1:0] r_run_base,   n_run_base;
    logic [AW-1:0] r_run_length, n_run_length;
    logic [AW-1:0] r_next_iova,  n_next_iova;
    logic          r_at_first,   n_at_first;

    // segment update stage
    logic [AW-1:0] va, span, keep, addr, seg_len, pgoff;
    logic [AW-1:0] iova_cur, mask_cur, len_cur, base_cur;
    logic [AW:0]   run_end;
    logic          disc;
    logic [63:0]   low_span;

    always_comb begin
        addr    = r_a_addr[AW-1:0];
        seg_len = AW'(r_a_len);

        // start of region: keep only bits above the highest differing bit
        va       = r_start_iova[AW-1:0];
        span     = (r_region_length[AW-1:0] - AW'(1) + va) ^ va;
        low_span = f_smear(64'(span)) | 64'd1;
        keep     = ~low_span[AW-1:0];

        iova_cur = r_at_first ? va : r_next_iova;
        mask_cur = r_at_first ? (r_supported_sizes[AW-1:0] & keep) : r_diff_mask;
        pgoff    = r_at_first ? (AW'(r_first_offset) & OFF_MASK) : '0;

        // discontinuity against the end of the current run
        run_end = {1'b0, r_run_base} + {1'b0, r_run_length};
        disc    = run_end[AW] || (run_end[AW-1:0] != addr);

        base_cur = r_run_base;
        len_cur  = r_run_length;
        if (disc) begin
            base_cur = addr;
            len_cur  = '0;
            mask_cur = mask_cur | ((addr + pgoff) ^ iova_cur);
            if (!r_at_first) begin
                mask_cur = mask_cur | iova_cur;
            end
        end

        n_diff_mask  = mask_cur;
        n_run_base   = base_cur;
        n_run_length = len_cur + seg_len;
        n_next_iova  = iova_cur + seg_len - pgoff;
        n_at_first   = 1'b0;

        // end of region returns to the idle state
        if (r_a_last) begin
            n_diff_mask  = '0;
            n_run_base   = '1;
            n_run_length = '0;
            n_next_iova  = '0;
            n_at_first   = 1'b1;
        end
    end

    logic          r_b_valid;
    logic [AW-1:0] r_b_mask;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_diff_mask  <= '0;
            r_run_base   <= '1;
            r_run_length <= '0;
            r_next_iova  <= '0;
            r_at_first   <= 1'b1;
            r_b_valid    <= 1'b0;
        end else if (adv) begin
            r_b_valid <= r_a_valid && r_a_last;
            if (r_a_valid) begin
                r_diff_mask  <= n_diff_mask;
                r_run_base   <= n_run_base;
                r_run_length <= n_run_length;
                r_next_iova  <= n_next_iova;
                r_at_first   <= n_at_first;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_b_mask <= mask_cur;
        end
    end

    // size selection stage
    logic [63:0] odp_size, dmask, lim, bm, bm_smear, n_size;

    always_comb begin
        odp_size = 64'd1 << r_odp_page_shift;
        dmask    = 64'(r_b_mask);
        // lowest set bit and everything below; all ones for an empty mask
        lim      = dmask ^ (dmask - 64'd1);
        bm       = r_supported_sizes & lim;
        bm_smear = f_smear(bm);
        if (r_odp_mode) begin
            n_size = ((r_supported_sizes & odp_size) != 64'd0) ? odp_size : 64'd0;
        end else begin
            n_size = bm_smear ^ (bm_smear >> 1);
        end
    end

    logic [63:0] r_c_size;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (adv) begin
            r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_c_size <= n_size;
        end
    end

    assign m_axis_tvalid = r_c_valid;
    assign m_axis_tdata  = r_c_size;

endmodule

// File: rtl/dbpsf_checker.sv
// ----------------------------------------------------------------------------
// dbpsf_checker
// Port-level checks for the page size finder, bound to the top level.
// ----------------------------------------------------------------------------
module dbpsf_checker
    import dbpsf_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic                  s_axis_tlast,   // last_segment
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [M_TDATA_W-1:0]  m_axis_tdata    // [63:0] best_page_size
);

    // count of last segments taken whose result has not left yet
    logic [3:0] r_pending;
    logic       in_last_xfer, out_xfer;

    assign in_last_xfer = s_axis_tvalid && s_axis_tready && s_axis_tlast;
    assign out_xfer     = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else begin
            r_pending <= r_pending + 4'(in_last_xfer) - 4'(out_xfer);
        end
    end

    // no result is pending straight after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // a stalled result holds its value
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // a page size is a single power of two or zero
    a_size_pow2: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> $onehot0(m_axis_tdata))
        else $error("page size not a power of two");

    // every result belongs to an earlier last segment
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> r_pending != 4'd0)
        else $error("result without a last segment");

endmodule

bind dma_best_page_size_finder_unit dbpsf_checker u_dbpsf_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// File: test/tb_dma_best_page_size_finder_unit.sv
// ----------------------------------------------------------------------------
// tb_dma_best_page_size_finder_unit
// Self-checking bench for the DMA best page size finder. Segments are pushed
// on the input stream and each one updates a local model of the region
// state. A region-closing segment queues the page size the model expects.
// The queued sizes are compared in order with the output stream. Directed
// cases cover the corner cases: address wrap, a region opening at the
// all-ones address, zero lengths, full-span regions and on-demand mode.
// These are followed by back-pressure, a sender pause and random regions
// under changing register settings.
// ----------------------------------------------------------------------------
module tb_dma_best_page_size_finder_unit;
    import dbpsf_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int DRAIN_CYCLES  = 10;
    localparam int RANDOM_ITEMS  = 550;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [S_TDATA_W-1:0]  s_axis_tdata;   // [63:0] seg_address, [95:64] seg_length
    logic                  s_axis_tlast;   // last_segment
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [M_TDATA_W-1:0]  m_axis_tdata;   // [63:0] best_page_size
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    // register copies, reset values
    logic [63:0] cfg_sizes  = 64'd0;
    logic [63:0] cfg_start  = 64'd0;
    logic [63:0] cfg_length = 64'd1;
    logic [11:0] cfg_offset = 12'd0;
    logic        cfg_odp    = 1'b0;
    logic [5:0]  cfg_shift  = 6'd12;

    // region state of the model
    logic [63:0] region_mask;
    logic [63:0] run_base;
    logic [63:0] run_len;
    logic [63:0] next_va;
    logic        region_open;

    logic [63:0] expected_sizes[$];
    int          mismatch_count = 0;
    int          cycle_count    = 0;
    int          sink_hold      = 0;
    bit          idle_enabled   = 1'b1;

    dma_best_page_size_finder_unit u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: run limit reached, %0d sizes outstanding", $time,
                     expected_sizes.size());
            $display("tb_dma_best_page_size_finder_unit: FAIL");
            $finish;
        end
    end

    // receiver: random stalls, or a counted hold-off when requested
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (sink_hold > 0) begin
                sink_hold--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= !(idle_enabled && ($urandom_range(0, 99) < 12));
            end
        end
    end

    // compare each output transfer with the oldest expected size
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_sizes.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected result, expected none, actual %h", $time,
                         m_axis_tdata);
            end else if (m_axis_tdata !== expected_sizes[0]) begin
                mismatch_count++;
                $display("%0t: page size mismatch, expected %h, actual %h", $time,
                         expected_sizes[0], m_axis_tdata);
                void'(expected_sizes.pop_front());
            end else begin
                void'(expected_sizes.pop_front());
            end
        end
    end

    function automatic void clear_region();
        region_mask = 64'd0;
        run_base    = '1;
        run_len     = 64'd0;
        next_va     = 64'd0;
        region_open = 1'b1;
    endfunction

    // advance the region state by one segment; returns 1 when a size is due
    function automatic bit predict_result(input logic [63:0] addr, input logic [31:0] len,
                                          input logic seg_last,
                                          output logic [63:0] exp_size);
        logic [63:0] pgoff;
        logic [63:0] span;
        logic [63:0] keep;
        logic [63:0] avail;
        logic [63:0] lim;
        logic [64:0] run_end;
        int          span_bits;
        int          low_zero;
        pgoff    = 64'd0;
        exp_size = 64'd0;
        // opening segment loads the mask from the region span
        if (region_open) begin
            span      = (cfg_length - 64'd1 + cfg_start) ^ cfg_start;
            span_bits = 1;
            for (int n = 0; n < 64; n++)
                if (span[n]) span_bits = n + 1;
            keep        = (span_bits >= 64) ? 64'd0 : ~((64'd1 << span_bits) - 64'd1);
            next_va     = cfg_start;
            region_mask = cfg_sizes & keep;
            pgoff       = {52'd0, cfg_offset};
        end
        // a wrapped or non-matching run end starts a new run
        run_end = {1'b0, run_base} + {1'b0, run_len};
        if (run_end[64] || (run_end[63:0] != addr)) begin
            run_base     = addr;
            run_len      = 64'd0;
            region_mask |= (addr + pgoff) ^ next_va;
            if (!region_open)
                region_mask |= next_va;
        end
        run_len     = run_len + {32'd0, len};
        next_va     = next_va + {32'd0, len} - pgoff;
        region_open = 1'b0;
        if (!seg_last)
            return 1'b0;
        // size selection on the closing segment
        if (cfg_odp) begin
            exp_size = ((cfg_sizes >> cfg_shift) & 64'd1) != 0 ? (64'd1 << cfg_shift) : 64'd0;
        end else begin
            avail = cfg_sizes;
            if (region_mask != 64'd0) begin
                low_zero = 0;
                while (low_zero < 63 && !region_mask[low_zero])
                    low_zero++;
                lim    = (low_zero >= 63) ? '1 : ((64'd2 << low_zero) - 64'd1);
                avail &= lim;
            end
            for (int n = 0; n < 64; n++)
                if (avail[n]) exp_size = 64'd1 << n;
        end
        clear_region();
        return 1'b1;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // one segment transfer; leaves tvalid high after acceptance
    task automatic send_segment(input logic [63:0] addr, input logic [31:0] len,
                                input logic seg_last);
        logic [63:0] exp_size;
        @(negedge i_clk);
        while (idle_enabled && ($urandom_range(0, 99) < 12)) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {len, addr};
        s_axis_tlast  <= seg_last;
        do @(posedge i_clk); while (!s_axis_tready);
        if (predict_result(addr, len, seg_last, exp_size))
            expected_sizes.push_back(exp_size);
    endtask

    // stop offering, then wait for every expected size plus pipeline drain
    task automatic wait_idle();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (expected_sizes.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_SUPPORTED_SIZES: cfg_sizes  = value;
            CFG_START_IOVA:      cfg_start  = value;
            CFG_REGION_LENGTH:   cfg_length = value;
            CFG_FIRST_OFFSET:    cfg_offset = value[11:0];
            CFG_ODP_MODE:        cfg_odp    = value[0];
            CFG_ODP_PAGE_SHIFT:  cfg_shift  = value[5:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic load_config(input logic [63:0] sizes, input logic [63:0] start,
                               input logic [63:0] length, input logic [11:0] offset,
                               input logic odp, input logic [5:0] shift);
        write_reg(CFG_SUPPORTED_SIZES, sizes);
        write_reg(CFG_START_IOVA, start);
        write_reg(CFG_REGION_LENGTH, length);
        write_reg(CFG_FIRST_OFFSET, {52'd0, offset});
        write_reg(CFG_ODP_MODE, {63'd0, odp});
        write_reg(CFG_ODP_PAGE_SHIFT, {58'd0, shift});
    endtask

    // register defaults: nothing supported gives size zero
    task automatic test_reset_state();
        send_segment(64'd0, 32'd0, 1'b1);
        wait_idle();
    endtask

    // contiguous runs, a gap, zero lengths and field extremes
    task automatic test_plain_regions();
        load_config(64'h0000_0000_4020_1000, 64'h0000_7F00_0000_0000, 64'h40_0000,
                    12'd0, 1'b0, 6'd12);
        send_segment(64'h0000_0001_0000_0000, 32'h0020_0000, 1'b0);
        send_segment(64'h0000_0001_0020_0000, 32'h0020_0000, 1'b1);
        send_segment(64'h0000_0001_0000_0000, 32'h0000_1000, 1'b0);
        send_segment(64'h0000_0002_0000_3000, 32'h003F_F000, 1'b1);
        send_segment(64'h0000_0000_0000_5000, 32'h0000_0000, 1'b0);
        send_segment(64'h0000_0000_0000_5000, 32'h0040_0000, 1'b1);
        // region opening at the all-ones address counts as contiguous
        send_segment('1, 32'hFFFF_FFFF, 1'b1);
        send_segment(64'd0, 32'hFFFF_FFFF, 1'b1);
        wait_idle();
    endtask

    // run end wrapping past the top of the address space
    task automatic test_address_wrap();
        load_config('1, 64'd0, 64'h2000, 12'd0, 1'b0, 6'd12);
        send_segment(64'hFFFF_FFFF_FFFF_F000, 32'h1000, 1'b0);
        send_segment(64'd0, 32'h1000, 1'b1);
        wait_idle();
    endtask

    // full-span region, maximum offset, empty mask, top-bit-only mask
    task automatic test_region_extremes();
        load_config('1, 64'd0, '1, 12'd0, 1'b0, 6'd12);
        send_segment(64'd0, 32'h1000, 1'b1);
        wait_idle();
        load_config(64'hFFFF_0000_FFFF_0000, '1, 64'd1, 12'd4095, 1'b0, 6'd12);
        send_segment(64'h1234_5000, 32'h10, 1'b1);
        wait_idle();
        load_config(64'd1, 64'd0, 64'd1, 12'd0, 1'b0, 6'd12);
        send_segment(64'd0, 32'h1, 1'b1);
        wait_idle();
        write_reg(CFG_SUPPORTED_SIZES, 64'h8000_0000_0000_0000);
        send_segment(64'd0, 32'h1, 1'b1);
        wait_idle();
    endtask

    // on-demand mode: only the fixed size is checked
    task automatic test_on_demand();
        load_config(64'h0000_0000_0000_1000, 64'h1000, 64'h10_0000, 12'd0, 1'b1, 6'd12);
        send_segment(64'h0000_0000_1234_0000, 32'h8000, 1'b0);
        send_segment(64'h0000_0000_9999_0000, 32'h8000, 1'b1);
        wait_idle();
        load_config(64'h8000_0000_0000_0000, 64'd0, 64'h1000, 12'd0, 1'b1, 6'd63);
        send_segment(64'h5000, 32'h1000, 1'b1);
        wait_idle();
        load_config(64'hFFFF_FFFF_FFFF_FFFE, 64'd0, 64'h1000, 12'd0, 1'b1, 6'd0);
        send_segment(64'h5000, 32'h1000, 1'b1);
        wait_idle();
    endtask

    // receiver holds off while single-segment regions keep coming
    task automatic test_output_backpressure();
        load_config(64'h0000_0000_4020_1000, 64'd0, 64'h20_0000, 12'd0, 1'b0, 6'd12);
        sink_hold = 40;
        for (int i = 0; i < 20; i++)
            send_segment(rand64() & ~64'h1F_FFFF, 32'h20_0000, 1'b1);
        wait_idle();
    endtask

    // sender stops until every size has come out, then goes on
    task automatic test_sender_pause();
        for (int i = 0; i < 6; i++)
            send_segment(64'h4000_0000 + 64'(i) * 64'h20_0000, 32'h20_0000, i == 5);
        wait_idle();
        for (int i = 0; i < 6; i++)
            send_segment(64'h8000_0000 + 64'(i) * 64'h1000, 32'h1000, i[0]);
        wait_idle();
    endtask

    // one region of mostly aligned, mostly contiguous segments
    task automatic send_random_region(inout int items);
        int          nseg;
        int          align_bits;
        logic [63:0] align;
        logic [63:0] addr;
        logic [31:0] len;
        nseg = $urandom_range(1, 8);
        case ($urandom_range(0, 5))
            0:       align_bits = 12;
            1:       align_bits = 16;
            2:       align_bits = 21;
            3:       align_bits = 30;
            default: align_bits = $urandom_range(0, 40);
        endcase
        align = (64'd1 << align_bits) - 64'd1;
        addr  = ((rand64() & ~align) | (cfg_start & align)) - {52'd0, cfg_offset};
        if ($urandom_range(0, 9) == 0)
            addr = rand64();
        for (int i = 0; i < nseg; i++) begin
            case ($urandom_range(0, 9))
                0:       len = 32'd0;
                1, 2:    len = $urandom();
                default: len = 32'($urandom_range(1, 64)) << 12;
            endcase
            send_segment(addr, len, i == nseg - 1);
            items++;
            // mostly contiguous, otherwise an aligned or a random jump
            case ($urandom_range(0, 19))
                0:       addr = rand64();
                1, 2:    addr = rand64() & ~align;
                default: addr = addr + {32'd0, len};
            endcase
        end
    endtask

    // random register settings per phase, random regions within
    task automatic test_random_regions();
        int          items;
        int          phase;
        logic [63:0] sizes;
        logic [63:0] start;
        logic [63:0] length;
        logic [11:0] offset;
        items = 0;
        phase = 0;
        while (items < RANDOM_ITEMS) begin
            // a stretch of phases with no idling on either side
            idle_enabled = !(phase >= 4 && phase <= 6);
            case ($urandom_range(0, 3))
                0:       sizes = 64'h0000_0000_4020_1000;
                1:       sizes = rand64();
                2:       sizes = '1;
                default: sizes = rand64() & ~64'hFFF;
            endcase
            case ($urandom_range(0, 5))
                0:       start = 64'd0;
                1:       start = '1;
                default: start = rand64() & ~((64'd1 << $urandom_range(0, 40)) - 64'd1);
            endcase
            case ($urandom_range(0, 5))
                0:       length = 64'd1;
                1:       length = '1;
                2:       length = rand64() | 64'd1;
                default: length = 64'($urandom_range(1, 65535)) << $urandom_range(0, 30);
            endcase
            offset = ($urandom_range(0, 9) < 7) ? start[11:0] : 12'($urandom_range(0, 4095));
            load_config(sizes, start, length, offset, $urandom_range(0, 4) == 0,
                        6'($urandom_range(0, 63)));
            repeat ($urandom_range(3, 10))
                send_random_region(items);
            wait_idle();
            phase++;
        end
        idle_enabled = 1'b1;
    endtask

    // stimulus sequence
    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = CFG_SUPPORTED_SIZES;
        i_cfg_data    = '0;
        clear_region();
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_state();
        test_plain_regions();
        test_address_wrap();
        test_region_extremes();
        test_on_demand();
        test_output_backpressure();
        test_sender_pause();
        test_random_regions();

        if (mismatch_count == 0) begin
            $display("tb_dma_best_page_size_finder_unit: PASS");
        end else begin
            $display("tb_dma_best_page_size_finder_unit: FAIL");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/dbpsf_pkg.sv
rtl/dma_best_page_size_finder_unit.sv
rtl/dbpsf_checker.sv
test/tb_dma_best_page_size_finder_unit.sv
